/* src/dual_ema_jump_detector_assert.svh */
// Assertion macros for the jump detector checker
`ifndef DUAL_EMA_JUMP_DETECTOR_ASSERT_SVH
`define DUAL_EMA_JUMP_DETECTOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DEJD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define DEJD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dejd_pkg.sv */
// Shared types, constants and helpers of the dual average jump detector
`timescale 1ns / 1ps

package dejd_pkg;

    localparam int IN_W       = 120;
    localparam int IN_USED    = 116;
    localparam int OUT_W      = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_TOL      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HAND_THR = 2'd2;

    localparam logic [10:0] TOL_RESET      = 11'd50;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
    localparam logic [10:0] HAND_THR_RESET = 11'd120;

    localparam logic signed [15:0] HEIGHT_MIN = -16'sd1300;

    // floor(2^25 / 5); the same constant serves /5 (>> 25) and /10 (>> 26)
    localparam logic [22:0] DIV_RECIP = 23'd6710886;
    // biases that make the dividends non-negative: 5 * 2^19 and 10 * 2^19
    localparam logic [22:0] OFF5      = 23'd2621440;
    localparam logic [22:0] OFF10     = 23'd5242880;
    localparam logic [20:0] AVG_BIAS  = 21'd524288;

    typedef enum logic [1:0] {
        KIND_HANDS = 2'd0,
        KIND_INSTR = 2'd1,
        KIND_STOMP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FR_EMPTY,
        FR_FOOT0,
        FR_FOOT1,
        FR_DONE
    } front_state_t;

    typedef struct packed {
        logic [10:0] tol;
        logic [15:0] timeout;
        logic [10:0] hand_thr;
    } cfg_t;

    // one frame's worth of results, queued between front and back
    typedef struct packed {
        logic [7:0]         uid;
        logic signed [12:0] center2;
        logic signed [12:0] off_r;
        logic signed [12:0] off_l;
        logic               inst_r;
        logic               inst_l;
        logic               stomp0;
        logic               stomp1;
    } rec_t;

    // clamp to -1300..0 mm and scale to Q.8
    function automatic logic signed [19:0] clamp_pos(input logic signed [15:0] y);
        logic signed [15:0] c;
        if (y < HEIGHT_MIN)
            c = HEIGHT_MIN;
        else if (y > 16'sd0)
            c = 16'sd0;
        else
            c = y;
        return {c[11:0], 8'h00};
    endfunction

endpackage

/* src/dejd_front.sv */
// Front end: takes frames, updates both feet's averages and jump state, queues results
`timescale 1ns / 1ps

module dejd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dejd_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dejd_pkg::IN_W-1:0]   in_data,
    output logic                        rec_valid,
    input  logic                        rec_ready,
    output dejd_pkg::rec_t              rec
);

    dejd_pkg::front_state_t state_reg, state_next;

    logic [dejd_pkg::IN_USED-1:0] frame_reg;

    logic signed [15:0] right_foot_y, left_foot_y;
    logic [10:0]        hip_left_x, hip_right_x, right_hand_x, left_hand_x;
    logic [31:0]        time_ms;
    logic [7:0]         user_id;

    logic accept, mul_en, mul_foot, fin_en, fin_foot;

    logic signed [19:0] fast_reg [2];
    logic signed [19:0] slow_reg [2];
    logic               open_reg [2];
    logic signed [19:0] floor_reg [2];
    logic [31:0]        start_reg [2];
    logic               stomp0_reg;

    // divide stage
    logic signed [19:0] p_mul;
    logic signed [22:0] fast_x, slow_x, p_x, num5, num10;
    logic [22:0]        x5_next, x10_next, x5_reg, x10_reg;
    logic [45:0]        prod5_next, prod10_next, prod5_reg, prod10_reg;

    // finish stage
    logic [20:0]        q5_0, q5, d5, d10, q10_w;
    logic [19:0]        q10_0, q10;
    logic [23:0]        r5, r10;
    logic signed [19:0] fast_n, slow_n, slow_use, p_fin;
    logic signed [20:0] fast_w, slow_w, floor_w, tol_w;
    logic               open_cur, opening, open1, stomp, timed_out;
    logic [31:0]        dur;
    logic signed [19:0] fast_next, slow_next;
    logic               open_next;

    // hands report
    logic [12:0]        center2, off_r, off_l;
    logic [11:0]        thr2;
    logic signed [13:0] thr2_s;

    assign right_foot_y = frame_reg[15:0];
    assign left_foot_y  = frame_reg[31:16];
    assign hip_left_x   = frame_reg[42:32];
    assign hip_right_x  = frame_reg[53:43];
    assign right_hand_x = frame_reg[64:54];
    assign left_hand_x  = frame_reg[75:65];
    assign time_ms      = frame_reg[107:76];
    assign user_id      = frame_reg[115:108];

    // sequencer: divide foot 0, then finish foot 0 while dividing foot 1, then finish foot 1
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        rec_valid  = 1'b0;
        case (state_reg)
            dejd_pkg::FR_EMPTY:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = dejd_pkg::FR_FOOT0;
            end
            dejd_pkg::FR_FOOT0:
                state_next = dejd_pkg::FR_FOOT1;
            dejd_pkg::FR_FOOT1:
                state_next = dejd_pkg::FR_DONE;
            dejd_pkg::FR_DONE:
            begin
                rec_valid = 1'b1;
                in_ready  = rec_ready;
                if (rec_ready)
                    state_next = in_valid ? dejd_pkg::FR_FOOT0 : dejd_pkg::FR_EMPTY;
            end
            default:
                state_next = dejd_pkg::FR_EMPTY;
        endcase
    end

    assign accept   = in_valid && in_ready;
    assign mul_en   = (state_reg == dejd_pkg::FR_FOOT0) || (state_reg == dejd_pkg::FR_FOOT1);
    assign mul_foot = (state_reg == dejd_pkg::FR_FOOT1);
    assign fin_foot = (state_reg == dejd_pkg::FR_DONE);
    assign fin_en   = (state_reg == dejd_pkg::FR_FOOT1) ||
                      ((state_reg == dejd_pkg::FR_DONE) && rec_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dejd_pkg::FR_EMPTY;
        else
            state_reg <= state_next;
    end

    // divide stage: dividends biased positive, multiplied by the reciprocal
    always_comb
    begin
        p_mul       = dejd_pkg::clamp_pos(mul_foot ? left_foot_y : right_foot_y);
        fast_x      = 23'(fast_reg[mul_foot]);
        slow_x      = 23'(slow_reg[mul_foot]);
        p_x         = 23'(p_mul);
        num5        = fast_x + (p_x <<< 2) + 23'sd2;
        num10       = (slow_x <<< 3) + slow_x + p_x + 23'sd5;
        x5_next     = 23'(num5) + dejd_pkg::OFF5;
        x10_next    = 23'(num10) + dejd_pkg::OFF10;
        prod5_next  = 46'(x5_next) * 46'(dejd_pkg::DIV_RECIP);
        prod10_next = 46'(x10_next) * 46'(dejd_pkg::DIV_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            frame_reg <= in_data[dejd_pkg::IN_USED-1:0];
        if (mul_en)
        begin
            x5_reg     <= x5_next;
            x10_reg    <= x10_next;
            prod5_reg  <= prod5_next;
            prod10_reg <= prod10_next;
        end
    end

    // finish stage: the estimate is low by at most one, fix with one compare
    always_comb
    begin
        q5_0   = prod5_reg[45:25];
        q10_0  = prod10_reg[45:26];
        r5     = {1'b0, x5_reg} - (24'(q5_0) << 2) - 24'(q5_0);
        r10    = {1'b0, x10_reg} - (24'(q10_0) << 3) - (24'(q10_0) << 1);
        q5     = q5_0 + ((r5 >= 24'd5) ? 21'd1 : 21'd0);
        q10    = q10_0 + ((r10 >= 24'd10) ? 20'd1 : 20'd0);
        q10_w  = {1'b0, q10};
        d5     = q5 - dejd_pkg::AVG_BIAS;
        d10    = q10_w - dejd_pkg::AVG_BIAS;
        fast_n = d5[19:0];
        slow_n = d10[19:0];
        p_fin  = dejd_pkg::clamp_pos(fin_foot ? left_foot_y : right_foot_y);

        open_cur = open_reg[fin_foot];
        slow_use = open_cur ? slow_reg[fin_foot] : slow_n;
        tol_w    = $signed({2'b00, cfg.tol, 8'h00});
        fast_w   = 21'(fast_n);
        slow_w   = 21'(slow_use);
        opening  = !open_cur && (fast_w > slow_w + tol_w);
        floor_w  = opening ? slow_w : 21'(floor_reg[fin_foot]);
        open1    = open_cur || opening;
        stomp    = open1 && (fast_w < floor_w + tol_w);
        dur      = time_ms - start_reg[fin_foot];
        // a jump opened in this frame has zero elapsed time, so only an old one times out
        timed_out = open_cur && !stomp && (dur > {16'h0000, cfg.timeout});

        fast_next = timed_out ? p_fin : fast_n;
        slow_next = timed_out ? p_fin : slow_use;
        open_next = open1 && !stomp && !timed_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg[0] <= '0;
            fast_reg[1] <= '0;
            slow_reg[0] <= '0;
            slow_reg[1] <= '0;
            open_reg[0] <= 1'b0;
            open_reg[1] <= 1'b0;
            stomp0_reg  <= 1'b0;
        end
        else if (fin_en)
        begin
            fast_reg[fin_foot] <= fast_next;
            slow_reg[fin_foot] <= slow_next;
            open_reg[fin_foot] <= open_next;
            if (!fin_foot)
                stomp0_reg <= stomp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_en && opening)
        begin
            floor_reg[fin_foot] <= slow_use;
            start_reg[fin_foot] <= time_ms;
        end
    end

    // hands report and instrument decisions, all in half pixels
    always_comb
    begin
        center2 = {2'b00, hip_left_x} + {2'b00, hip_right_x};
        off_r   = center2 - {1'b0, right_hand_x, 1'b0};
        off_l   = center2 - {1'b0, left_hand_x, 1'b0};
        thr2    = {cfg.hand_thr, 1'b0};
        thr2_s  = $signed({2'b00, thr2});

        rec.uid     = user_id;
        rec.center2 = $signed(center2);
        rec.off_r   = $signed(off_r);
        rec.off_l   = $signed(off_l);
        rec.inst_r  = $signed({off_r[12], off_r}) < -thr2_s;
        rec.inst_l  = $signed({off_l[12], off_l}) > thr2_s;
        rec.stomp0  = stomp0_reg;
        rec.stomp1  = stomp;
    end

endmodule

/* src/dejd_queue.sv */
// Two-entry queue of frame records between front and back
`timescale 1ns / 1ps

module dejd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  dejd_pkg::rec_t push_rec,
    output logic           head_valid,
    input  logic           pop,
    output dejd_pkg::rec_t head_rec
);

    dejd_pkg::rec_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;

    assign head_valid = (count_reg != 2'd0);
    assign head_rec   = entry_reg[rd_ptr_reg];
    // a slot freed by this cycle's pop may be refilled at once
    assign push_ready = (count_reg != 2'd2) || pop;
    assign push       = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

/* src/dejd_back.sv */
// Back end: unrolls each queued frame into its result stream, one result per cycle while the output is not stalled
`timescale 1ns / 1ps

module dejd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  dejd_pkg::rec_t              head_rec,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dejd_pkg::OUT_W-1:0]  m_data,
    output logic [1:0]                  m_user,
    output logic                        m_last
);

    localparam logic [4:0] EV_HANDS  = 5'b00001;
    localparam logic [4:0] EV_INST_R = 5'b00010;
    localparam logic [4:0] EV_INST_L = 5'b00100;
    localparam logic [4:0] EV_STOMP0 = 5'b01000;
    localparam logic [4:0] EV_STOMP1 = 5'b10000;

    logic [4:0] done_reg, done_next;
    logic [4:0] mask, pending, sel;
    logic       emit, is_last;

    logic                  valid_reg, valid_next;
    dejd_pkg::kind_t       kind_reg, kind_next;
    logic [7:0]            uid_reg;
    logic signed [12:0]    a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic                  last_reg;

    always_comb
    begin
        mask    = {head_rec.stomp1, head_rec.stomp0, head_rec.inst_l, head_rec.inst_r, 1'b1};
        pending = mask & ~done_reg;
        sel     = pending & (~pending + 5'd1);
        is_last = ((pending & ~sel) == 5'd0);
        emit    = head_valid && (!valid_reg || m_ready);
        pop     = emit && is_last;

        done_next = done_reg;
        if (emit)
            done_next = is_last ? 5'd0 : (done_reg | sel);

        valid_next = emit ? 1'b1 : (valid_reg && !m_ready);

        kind_next = dejd_pkg::KIND_HANDS;
        a_next    = 13'sd0;
        b_next    = 13'sd0;
        c_next    = 13'sd0;
        case (sel)
            EV_HANDS:
            begin
                kind_next = dejd_pkg::KIND_HANDS;
                a_next    = head_rec.center2;
                b_next    = head_rec.off_r;
                c_next    = head_rec.off_l;
            end
            EV_INST_R:
                kind_next = dejd_pkg::KIND_INSTR;
            EV_INST_L:
            begin
                kind_next = dejd_pkg::KIND_INSTR;
                a_next    = 13'sd1;
            end
            EV_STOMP0:
                kind_next = dejd_pkg::KIND_STOMP;
            EV_STOMP1:
            begin
                kind_next = dejd_pkg::KIND_STOMP;
                a_next    = 13'sd1;
            end
            default:
                kind_next = dejd_pkg::KIND_HANDS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 5'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            uid_reg  <= head_rec.uid;
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            last_reg <= is_last;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {1'b0, c_reg, b_reg, a_reg, uid_reg};
    assign m_user  = kind_reg;
    assign m_last  = last_reg;

endmodule

/* src/dual_ema_jump_detector.sv */
// A frame's first result passes the front's FOOT0, FOOT1 and DONE states, the queue and
// the back's output register. The front takes a new frame when idle or as it hands its
// record to the queue, as each foot runs in turn through one shared reciprocal-multiply
// divider followed by a correction stage; the back sends one result per cycle while the
// output is not stalled, 1 to 5 results per frame. Reset (asynchronous, active low) clears averages,
// jump flags, queue and output valid, and loads tolerance 50, timeout 2000 and hand threshold 120.
`timescale 1ns / 1ps

module dual_ema_jump_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // right_foot_y, left_foot_y, hip_left_x, hip_right_x, right_hand_x, left_hand_x,
    // time_ms, user_id, zero pad
    input  logic [dejd_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // user_id_out, value_a, value_b, value_c, zero pad
    output logic [dejd_pkg::OUT_W-1:0]        m_axis_tdata,
    // event_kind
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [dejd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dejd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [10:0]    tol_reg, tol_next;
    logic [15:0]    timeout_reg, timeout_next;
    logic [10:0]    hand_thr_reg, hand_thr_next;
    dejd_pkg::cfg_t cfg;

    logic           rec_valid, rec_ready, head_valid, pop;
    dejd_pkg::rec_t rec, head_rec;

    always_comb
    begin
        tol_next      = tol_reg;
        timeout_next  = timeout_reg;
        hand_thr_next = hand_thr_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                dejd_pkg::CFG_TOL:      tol_next      = cfg_wdata[10:0];
                dejd_pkg::CFG_TIMEOUT:  timeout_next  = cfg_wdata;
                dejd_pkg::CFG_HAND_THR: hand_thr_next = cfg_wdata[10:0];
                default:                tol_next      = tol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= dejd_pkg::TOL_RESET;
            timeout_reg  <= dejd_pkg::TIMEOUT_RESET;
            hand_thr_reg <= dejd_pkg::HAND_THR_RESET;
        end
        else
        begin
            tol_reg      <= tol_next;
            timeout_reg  <= timeout_next;
            hand_thr_reg <= hand_thr_next;
        end
    end

    assign cfg.tol      = tol_reg;
    assign cfg.timeout  = timeout_reg;
    assign cfg.hand_thr = hand_thr_reg;

    dejd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    dejd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (rec_valid),
        .push_ready (rec_ready),
        .push_rec   (rec),
        .head_valid (head_valid),
        .pop        (pop),
        .head_rec   (head_rec)
    );

    dejd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_user     (m_axis_tuser),
        .m_last     (m_axis_tlast)
    );

endmodule

/* src/dejd_checker.sv */
// Port-level checks on the result stream, bound to the top level
`timescale 1ns / 1ps
`include "dual_ema_jump_detector_assert.svh"

module dejd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [dejd_pkg::OUT_W-1:0]  m_axis_tdata,
    input logic [1:0]                  m_axis_tuser,
    input logic                        m_axis_tlast
);

    logic take, not_hands;

    assign take      = m_axis_tvalid && m_axis_tready;
    assign not_hands = m_axis_tuser != dejd_pkg::KIND_HANDS;

    `DEJD_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
    `DEJD_ASSERT_NOW(a_event_fields, m_axis_tvalid && not_hands, m_axis_tdata[46:21] == 26'd0 && (m_axis_tdata[20:8] == 13'd0 || m_axis_tdata[20:8] == 13'd1), "instrument or stomp result with bad values")
    `DEJD_ASSERT_NEXT(a_frame_starts_hands, take && m_axis_tlast, !m_axis_tvalid || !not_hands, "frame did not start with a hands report")
    `DEJD_ASSERT_NEXT(a_one_hands_per_frame, take && !m_axis_tlast, !m_axis_tvalid || not_hands, "second hands report inside a frame")

endmodule

bind dual_ema_jump_detector dejd_checker u_dejd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
